@@ rtl/lfr_pkg.sv @@
// Shared types, codes and helpers for the LIN frame receiver.
`default_nettype none

package lfr_pkg;

	// Length table geometry
	localparam int LEN_BITS = 4;
	localparam int NUM_IDS  = 64;
	localparam int TAB_W    = 256;
	localparam int EXT_W    = NUM_IDS * LEN_BITS;
	localparam int POS_W    = $clog2(EXT_W);

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	// Register map, index = paddr[5:3]
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_PID_MASK  = 3'd0;
	localparam reg_idx_t REG_LEN_LOW   = 3'd1;
	localparam reg_idx_t REG_LEN_MID   = 3'd2;
	localparam reg_idx_t REG_LEN_HIGH  = 3'd3;
	localparam reg_idx_t REG_LEN_TOP   = 3'd4;
	localparam reg_idx_t REG_MAX_LEN   = 3'd5;

	localparam logic [3:0] MAX_LEN_RST = 4'd8;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_HEADER = 2'd0;
	localparam kind_t KIND_DATA   = 2'd1;
	localparam kind_t KIND_END    = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_TIMEOUT  = 3'd1;
	localparam status_t ST_PARITY   = 3'd2;
	localparam status_t ST_UNKNOWN  = 3'd3;
	localparam status_t ST_LENGTH   = 3'd4;
	localparam status_t ST_CHECKSUM = 3'd5;

	typedef enum logic [3:0] {
		PH_SYNC = 4'b0001,
		PH_PID  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_CHK  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		kind_t      result_kind;
		status_t    status;
		logic [5:0] frame_id;
		logic [3:0] frame_len;
		logic [3:0] byte_index;
		logic [7:0] data_byte;
	} result_t;

	typedef struct packed {
		logic [63:0]      pid_mask;
		logic [TAB_W-1:0] len_tab;
		logic [3:0]       max_length;
	} cfg_t;

	// Protected identifier: id plus the two LIN parity bits
	function automatic logic [7:0] with_parity(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

endpackage

`default_nettype wire

@@ rtl/lfr_cfg_regs.sv @@
// APB register file for the LIN frame receiver configuration.
`default_nettype none

module lfr_cfg_regs import lfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [63:0] pid_mask_q;
	logic [63:0] len_low_q;
	logic [63:0] len_mid_q;
	logic [63:0] len_high_q;
	logic [63:0] len_top_q;
	logic [3:0]  max_len_q;
	reg_idx_t    idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_mask_q <= '0;
			len_low_q  <= '0;
			len_mid_q  <= '0;
			len_high_q <= '0;
			len_top_q  <= '0;
			max_len_q  <= MAX_LEN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PID_MASK: pid_mask_q <= pwdata;
				REG_LEN_LOW:  len_low_q  <= pwdata;
				REG_LEN_MID:  len_mid_q  <= pwdata;
				REG_LEN_HIGH: len_high_q <= pwdata;
				REG_LEN_TOP:  len_top_q  <= pwdata;
				REG_MAX_LEN:  max_len_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PID_MASK: prdata = pid_mask_q;
			REG_LEN_LOW:  prdata = len_low_q;
			REG_LEN_MID:  prdata = len_mid_q;
			REG_LEN_HIGH: prdata = len_high_q;
			REG_LEN_TOP:  prdata = len_top_q;
			REG_MAX_LEN:  prdata = {60'd0, max_len_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.pid_mask   = pid_mask_q;
	assign cfg.len_tab    = {len_top_q, len_high_q, len_mid_q, len_low_q};
	assign cfg.max_length = max_len_q;

endmodule

`default_nettype wire

@@ rtl/lfr_frame_core.sv @@
// Frame state and per-word decode: sync hunt, PID check, body and checksum.
`default_nettype none

module lfr_frame_core import lfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  step_en,
	input  wire item_t in_word,
	output logic       has_res,
	output result_t    res
);

	phase_t         phase_q, ph_d;
	logic [5:0]     cur_id_q, id_d;
	logic [3:0]     blen_q, blen_d;
	logic [3:0]     seen_q, seen_d;
	logic [7:0]     sum_q, sum_d;

	logic [5:0]          pid_id;
	logic [7:0]          pid_expect;
	logic [EXT_W-1:0]    tab_ext;
	logic [POS_W-1:0]    bit_pos;
	logic [LEN_BITS-1:0] len_full;
	logic [3:0]          len4;
	logic [8:0]          sum_add;

	assign pid_id     = in_word.rx_byte[5:0];
	assign pid_expect = with_parity(pid_id);
	assign tab_ext    = EXT_W'(cfg.len_tab);
	assign bit_pos    = POS_W'(int'(pid_id) * LEN_BITS);
	assign len_full   = tab_ext[bit_pos +: LEN_BITS];
	assign len4       = len_full[3:0];
	// add with carry out; the body step folds the carry back in (end-around)
	assign sum_add    = {1'b0, sum_q} + {1'b0, in_word.rx_byte};

	always_comb begin
		ph_d    = phase_q;
		id_d    = cur_id_q;
		blen_d  = blen_q;
		seen_d  = seen_q;
		sum_d   = sum_q;
		has_res = 1'b0;
		res     = '0;
		if (in_word.func) begin
			ph_d       = PH_SYNC;
			has_res    = 1'b1;
			res.status = ST_TIMEOUT;
			if (phase_q == PH_SYNC || phase_q == PH_PID) begin
				res.result_kind = KIND_HEADER;
			end else begin
				res.result_kind = KIND_END;
				res.frame_id    = cur_id_q;
				res.frame_len   = blen_q;
			end
		end else begin
			unique case (phase_q)
				PH_SYNC: begin
					if (in_word.rx_byte == SYNC_BYTE)
						ph_d = PH_PID;
				end
				PH_PID: begin
					ph_d            = PH_SYNC;
					has_res         = 1'b1;
					res.result_kind = KIND_HEADER;
					res.frame_id    = pid_id;
					res.data_byte   = in_word.rx_byte;
					priority if (in_word.rx_byte != pid_expect) begin
						res.status = ST_PARITY;
					end else if (!cfg.pid_mask[pid_id]) begin
						res.status = ST_UNKNOWN;
					end else if (len_full > LEN_BITS'(cfg.max_length)) begin
						res.status    = ST_LENGTH;
						res.frame_len = len4;
					end else begin
						res.status    = ST_OK;
						res.frame_len = len4;
						id_d          = pid_id;
						blen_d        = len4;
						seen_d        = '0;
						sum_d         = '0;
						ph_d          = (len4 == 4'd0) ? PH_CHK : PH_BODY;
					end
				end
				PH_BODY: begin
					has_res         = 1'b1;
					res.result_kind = KIND_DATA;
					res.status      = ST_OK;
					res.frame_id    = cur_id_q;
					res.frame_len   = blen_q;
					res.byte_index  = seen_q;
					res.data_byte   = in_word.rx_byte;
					sum_d           = sum_add[8] ? (sum_add[7:0] + 8'd1) : sum_add[7:0];
					seen_d          = seen_q + 4'd1;
					if (seen_d >= blen_q)
						ph_d = PH_CHK;
				end
				PH_CHK: begin
					ph_d            = PH_SYNC;
					has_res         = 1'b1;
					res.result_kind = KIND_END;
					res.status      = (in_word.rx_byte == ~sum_q) ? ST_OK : ST_CHECKSUM;
					res.frame_id    = cur_id_q;
					res.frame_len   = blen_q;
					res.data_byte   = in_word.rx_byte;
				end
				default: ph_d = PH_SYNC;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC;
			cur_id_q <= '0;
			blen_q   <= '0;
			seen_q   <= '0;
			sum_q    <= '0;
		end else if (step_en) begin
			phase_q  <= ph_d;
			cur_id_q <= id_d;
			blen_q   <= blen_d;
			seen_q   <= seen_d;
			sum_q    <= sum_d;
		end
	end

`ifndef SYNTHESIS
	a_body_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (blen_q != 4'd0 && seen_q < blen_q))
		else $error("body phase with empty or overrun length");

	a_chk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_CHK |=> phase_q == PH_SYNC)
		else $error("checksum word did not end frame");

	a_fail_resync: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && in_word.func |=> phase_q == PH_SYNC)
		else $error("receive failure did not return to sync hunt");

	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SYNC && !in_word.func |-> !has_res)
		else $error("result produced during sync hunt");
`endif

endmodule

`default_nettype wire

@@ rtl/lin_frame_receiver_unit.sv @@
// Top level of the LIN slave frame receiver (classic checksum).
// An accepted word is held in the input register (s1), then its result in the result register.
// Throughput: one word per cycle; the input register refills while the
// result register drains, stalled only when the result register is held.
// Reset (arst_n low, async): sync hunt, pipeline empty, mask and length
// tables zero, max_length 8.
`default_nettype none

module lin_frame_receiver_unit import lfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// receive words
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	// result words
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;
	logic    adv;
	logic    has_res;
	result_t res_d;

	lfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Word in s1 moves on when the result register is free or draining.
	// A word with no result still advances (it only updates frame state).
	assign adv        = valid_s1 & (~res_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	lfr_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (adv),
		.in_word (item_s1),
		.has_res (has_res),
		.res     (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= has_res;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && result_stall |=> valid_s1)
		else $error("input stage dropped a word while result stalled");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (!res_valid_q || !result_stall))
		else $error("advance into a held result register");
`endif

endmodule

`default_nettype wire

@@ sim/lin_frame_receiver_unit_tb.sv @@
// Self-checking testbench for the LIN frame receiver: random frames, stalls and register settings.
`timescale 1ns / 100ps

module lin_frame_receiver_unit_tb;
	import lfr_pkg::*;

	// Hard stop, so that a run that hangs still ends.
	localparam int CYCLE_LIMIT = 400_000;
	// Quiet cycles allowed after the last expected word.
	localparam int SETTLE_CYCLES = 8;

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         item_valid   = 1'b0;
	logic         item_stall;
	item_t        item         = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_t      result;
	logic         psel         = 1'b0;
	logic         penable      = 1'b0;
	logic         pwrite       = 1'b0;
	logic [5:0]   paddr        = '0;
	logic [63:0]  pwdata       = '0;
	logic [63:0]  prdata;
	logic         pready;

	lin_frame_receiver_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	// Shadow of the register file, updated as each write completes.
	logic [63:0]      id_mask_copy = '0;
	logic [TAB_W-1:0] len_tab_copy = '0;
	logic [3:0]       max_len_copy = MAX_LEN_RST;

	// Receiver state as the block should hold it.
	phase_t     rx_phase  = PH_SYNC;
	logic [5:0] cur_id    = '0;
	logic [3:0] cur_len   = '0;
	logic [3:0] seen_cnt  = '0;
	logic [7:0] body_sum  = '0;

	item_t   rx_words_q[$];     // words waiting to be driven
	result_t frame_results_q[$]; // outcomes predicted, not yet seen
	int      mismatches = 0;
	int      words_queued = 0;   // words that drive the receiver (noise excluded)
	int      cycles = 0;

	// ------------------------------------------------------------------
	// Frame arithmetic
	// ------------------------------------------------------------------

	// Protected identifier: id with the two LIN parity bits on top.
	function automatic logic [7:0] protect_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Classic checksum step: 8-bit add with end-around carry.
	function automatic logic [7:0] sum_eac(input logic [7:0] acc, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

	function automatic logic [3:0] len_of(input logic [5:0] id);
		return len_tab_copy[id * LEN_BITS +: LEN_BITS];
	endfunction

	function automatic result_t make_result(input kind_t k, input status_t st,
			input logic [5:0] id, input logic [3:0] n, input logic [3:0] idx,
			input logic [7:0] b);
		result_t r;
		r.result_kind = k;
		r.status      = st;
		r.frame_id    = id;
		r.frame_len   = n;
		r.byte_index  = idx;
		r.data_byte   = b;
		return r;
	endfunction

	// Advances the receiver shadow by one accepted word. Returns 1 when the
	// word produces an outcome, placed in r.
	function automatic bit predict_rx_word(input item_t w, output result_t r);
		logic [5:0] id;
		logic [3:0] n;
		r = '0;
		// receive failure: aborts whatever is in progress
		if (w.func) begin
			if (rx_phase == PH_SYNC || rx_phase == PH_PID)
				r = make_result(KIND_HEADER, ST_TIMEOUT, '0, '0, '0, '0);
			else
				r = make_result(KIND_END, ST_TIMEOUT, cur_id, cur_len, '0, '0);
			rx_phase = PH_SYNC;
			return 1'b1;
		end
		case (rx_phase)
			PH_SYNC: begin
				// anything but the sync byte is dropped silently
				if (w.rx_byte == SYNC_BYTE)
					rx_phase = PH_PID;
				return 1'b0;
			end
			PH_PID: begin
				id = w.rx_byte[5:0];
				n  = len_of(id);
				rx_phase = PH_SYNC;
				if (w.rx_byte != protect_id(id)) begin
					r = make_result(KIND_HEADER, ST_PARITY, id, '0, '0, w.rx_byte);
				end else if (!id_mask_copy[id]) begin
					r = make_result(KIND_HEADER, ST_UNKNOWN, id, '0, '0, w.rx_byte);
				end else if (n > max_len_copy) begin
					r = make_result(KIND_HEADER, ST_LENGTH, id, n, '0, w.rx_byte);
				end else begin
					cur_id   = id;
					cur_len  = n;
					seen_cnt = '0;
					body_sum = '0;
					// empty body goes straight to the checksum byte
					rx_phase = (n == 4'd0) ? PH_CHK : PH_BODY;
					r = make_result(KIND_HEADER, ST_OK, id, n, '0, w.rx_byte);
				end
				return 1'b1;
			end
			PH_BODY: begin
				r = make_result(KIND_DATA, ST_OK, cur_id, cur_len, seen_cnt, w.rx_byte);
				body_sum = sum_eac(body_sum, w.rx_byte);
				seen_cnt = seen_cnt + 4'd1;
				if (seen_cnt >= cur_len)
					rx_phase = PH_CHK;
				return 1'b1;
			end
			default: begin
				r = make_result(KIND_END, (w.rx_byte == ~body_sum) ? ST_OK : ST_CHECKSUM,
					cur_id, cur_len, '0, w.rx_byte);
				rx_phase = PH_SYNC;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: feeds queued words in bursts with random gaps.
	// The stall input only tells whether the current word was taken.
	// ------------------------------------------------------------------
	int      burst_left = 0;
	int      gap_left   = 0;
	result_t predicted;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				if (predict_rx_word(item, predicted))
					frame_results_q.push_back(predicted);
			end
			if (!item_valid || !item_stall) begin
				if (gap_left > 0 || rx_words_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					item_valid <= 1'b0;
				end else begin
					item       <= rx_words_q.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// next burst; a third of them run on with no gap
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each taken outcome word against the oldest prediction.
	// Stall runs in modes: none, scattered, or long holds.
	// ------------------------------------------------------------------
	int      stall_mode = 0;
	int      mode_left  = 0;
	int      hold_left  = 0;
	result_t oldest;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (frame_results_q.size() == 0) begin
					$error("unexpected outcome word: kind %0d status %0d id %0d",
						result.result_kind, result.status, result.frame_id);
					mismatches++;
				end else begin
					oldest = frame_results_q.pop_front();
					check_field("result_kind", oldest.result_kind, result.result_kind);
					check_field("status", oldest.status, result.status);
					check_field("frame_id", oldest.frame_id, result.frame_id);
					check_field("frame_len", oldest.frame_len, result.frame_len);
					check_field("byte_index", oldest.byte_index, result.byte_index);
					check_field("data_byte", oldest.data_byte, result.data_byte);
				end
			end

			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 99) < 35);
				default: begin
					if (hold_left > 0) begin
						hold_left--;
						result_stall <= 1'b1;
					end else if ($urandom_range(0, 99) < 10) begin
						hold_left = $urandom_range(1, 12);
						result_stall <= 1'b1;
					end else begin
						result_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_word(input logic f, input logic [7:0] b);
		item_t w;
		w.func    = f;
		w.rx_byte = b;
		rx_words_q.push_back(w);
		words_queued++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Register write: setup phase, then access until pready.
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PID_MASK: id_mask_copy = val;
			REG_LEN_LOW:  len_tab_copy[63:0]    = val;
			REG_LEN_MID:  len_tab_copy[127:64]  = val;
			REG_LEN_HIGH: len_tab_copy[191:128] = val;
			REG_LEN_TOP:  len_tab_copy[255:192] = val;
			REG_MAX_LEN:  max_len_copy = val[3:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [63:0] m, input logic [255:0] t,
			input logic [3:0] mx);
		write_reg(REG_PID_MASK, m);
		write_reg(REG_LEN_LOW, t[63:0]);
		write_reg(REG_LEN_MID, t[127:64]);
		write_reg(REG_LEN_HIGH, t[191:128]);
		write_reg(REG_LEN_TOP, t[255:192]);
		write_reg(REG_MAX_LEN, {60'd0, mx});
	endtask

	// Block idle: nothing queued, nothing in flight, nothing outstanding.
	// Sampled on the falling edge so the clocked blocks have settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_words_q.size() != 0 || item_valid || frame_results_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// One frame for id under the current settings. A rejected header stops
	// after the identifier. cut_at >= 0 swaps the word at that position
	// (0 = identifier) for a receive failure.
	task automatic send_frame(input logic [5:0] id, input bit good_sum, input int cut_at);
		logic [3:0] n;
		logic [7:0] b;
		logic [7:0] acc;
		n   = len_of(id);
		acc = '0;
		push_word(1'b0, SYNC_BYTE);
		if (cut_at == 0) begin
			push_word(1'b1, '0);
			return;
		end
		push_word(1'b0, protect_id(id));
		if (!id_mask_copy[id] || n > max_len_copy)
			return;
		for (int k = 1; k <= n; k++) begin
			if (cut_at == k) begin
				push_word(1'b1, '0);
				return;
			end
			b   = 8'($urandom_range(0, 255));
			acc = sum_eac(acc, b);
			push_word(1'b0, b);
		end
		if (cut_at == n + 1)
			push_word(1'b1, '0);
		else if (good_sum)
			push_word(1'b0, ~acc);
		else
			push_word(1'b0, ~acc ^ 8'($urandom_range(1, 255)));
	endtask

	// Mostly well-formed frames on ids that pass the header checks, the
	// rest broken headers, lone failures and line noise.
	task automatic run_random(input int target);
		int         start;
		int         sel;
		int         n_noise;
		int         ok_ids[$];
		logic [5:0] id;
		for (int k = 0; k < NUM_IDS; k++)
			if (id_mask_copy[k] && len_of(6'(k)) <= max_len_copy)
				ok_ids.push_back(k);
		start = words_queued;
		while (words_queued - start < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				if (ok_ids.size() != 0 && $urandom_range(0, 9) != 0)
					id = 6'(ok_ids[$urandom_range(0, ok_ids.size() - 1)]);
				else
					id = 6'($urandom_range(0, 63));
				send_frame(id, $urandom_range(0, 99) < 85,
					($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 17)) : -1);
			end else if (sel < 78) begin
				// sync then a raw byte, usually bad parity
				push_word(1'b0, SYNC_BYTE);
				push_word(1'b0, 8'($urandom_range(0, 255)));
			end else if (sel < 88) begin
				push_word(1'b1, 8'($urandom_range(0, 255)));
			end else begin
				// noise between frames does not count toward the target
				n_noise = $urandom_range(1, 4);
				repeat (n_noise) begin
					push_word(1'b0, 8'($urandom_range(0, 255)));
					words_queued--;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: mask is clear, so any good identifier is unknown.
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd5));
		wait_idle();

		// Directed settings: id0 len 2, id1 len 0, id2 len 9, id3 len 1,
		// id4 len 15 (over the limit of 8), id63 not accepted.
		configure(64'h7FFF_FFFF_FFFF_FFFF,
			{rand64(), rand64(), rand64(), 64'h0000_0000_000F_1902}, 4'd8);
		@(negedge clk);
		push_word(1'b0, 8'h3C);                 // dropped in sync hunt
		push_word(1'b1, 8'h00);                 // failure in sync hunt
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b1, 8'hFF);                 // failure awaiting identifier
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, 8'h00);                 // parity error
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd63));     // unknown id
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd4));      // length too big
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd1));      // empty body
		push_word(1'b0, 8'hFF);                 //   checksum of nothing
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd0));
		push_word(1'b0, 8'h55);                 // sync value inside a body
		push_word(1'b0, 8'hFF);                 // carry wraps around
		push_word(1'b0, 8'hAA);
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd3));
		push_word(1'b0, 8'h12);
		push_word(1'b0, 8'h00);                 // bad checksum
		push_word(1'b0, SYNC_BYTE);
		push_word(1'b0, protect_id(6'd0));
		push_word(1'b0, 8'h01);
		push_word(1'b1, 8'h00);                 // failure inside the body
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(rand64(), {rand64(), rand64(), rand64(), rand64()}, MAX_LEN_RST);
				1: configure('1, {rand64(), rand64(), rand64(), rand64()}, 4'd15);
				// only empty-body ids get through
				2: configure('1, {rand64(), rand64(), rand64(), rand64()}, 4'd0);
				// every body at full length
				3: configure(rand64(), '1, 4'd15);
				4: configure('0, {rand64(), rand64(), rand64(), rand64()},
					4'($urandom_range(0, 15)));
				default: configure(rand64(), {rand64(), rand64(), rand64(), rand64()},
					4'($urandom_range(0, 15)));
			endcase
			@(negedge clk);
			run_random((p == 4) ? 50 : 200);
			wait_idle();
		end

		if (mismatches == 0 && frame_results_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
